FILE: design/dllc_pkg.sv
// package for the linked list node pool: transfer types and operation codes
// no dependencies
`timescale 1ns / 1ps
package dllc_pkg;

    localparam int DefNodes     = 16;
    localparam int DefValueBits = 32;

    // operation codes
    localparam logic [4:0] OP_CLEAR      = 5'd0;
    localparam logic [4:0] OP_INS_FIRST  = 5'd1;
    localparam logic [4:0] OP_INS_LAST   = 5'd2;
    localparam logic [4:0] OP_FIRST      = 5'd3;
    localparam logic [4:0] OP_LAST       = 5'd4;
    localparam logic [4:0] OP_GET_FIRST  = 5'd5;
    localparam logic [4:0] OP_GET_LAST   = 5'd6;
    localparam logic [4:0] OP_DEL_FIRST  = 5'd7;
    localparam logic [4:0] OP_DEL_LAST   = 5'd8;
    localparam logic [4:0] OP_DEL_AFTER  = 5'd9;
    localparam logic [4:0] OP_DEL_BEFORE = 5'd10;
    localparam logic [4:0] OP_INS_AFTER  = 5'd11;
    localparam logic [4:0] OP_INS_BEFORE = 5'd12;
    localparam logic [4:0] OP_GET        = 5'd13;
    localparam logic [4:0] OP_SET        = 5'd14;
    localparam logic [4:0] OP_NEXT       = 5'd15;
    localparam logic [4:0] OP_PREV       = 5'd16;
    localparam logic [4:0] OP_IS_ACTIVE  = 5'd17;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               error;
        logic               cursor_valid;
    } t_rsp;

endpackage

FILE: design/doubly_linked_list_with_cursor.sv
// doubly linked list in a node pool; one command in, one result strobe out
// sequence: read the node the op works on (R1), for del_after/del_before also
// read the deleted neighbor's link (R2), then write link slot 0 (X) and slot 1 (W)
// and register the result strobe after W; busy while working, so a new command is
// taken only after the read-then-two-write sequence; the receiver cannot stall results
// reset: head, tail and cursor go to none and all nodes free; memories uncleared
`timescale 1ns / 1ps
module doubly_linked_list_with_cursor #(
    parameter int NODES      = dllc_pkg::DefNodes,
    parameter int VALUE_BITS = dllc_pkg::DefValueBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  dllc_pkg::t_cmd i_cmd,
    output logic          o_done,
    output dllc_pkg::t_rsp o_rsp
);
    import dllc_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NONE = PW'(NODES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_R1   = 3'd1;
    localparam logic [2:0] S_R2   = 3'd2;
    localparam logic [2:0] S_X    = 3'd3;
    localparam logic [2:0] S_W    = 3'd4;

    logic [2:0]       r_state, n_state;
    t_cmd             r_cmd;
    logic [PW-1:0]    r_head, r_tail, r_cur, r_lnk;
    logic [PW-1:0]    n_head, n_tail, n_cur;
    logic [NODES-1:0] r_use, n_use;
    logic             r_done;
    t_rsp             r_rsp, n_rsp;

    logic [PW-1:0]         nq, pq;
    logic [VALUE_BITS-1:0] vq;
    logic [AW-1:0]         alloc_idx;
    logic                  full;
    logic [PW-1:0]         nn;
    logic                  re;
    logic [AW-1:0]         raddr;
    logic [PW-1:0]         rptr;

    logic          nx_we [2];
    logic [PW-1:0] nx_wa [2];
    logic [PW-1:0] nx_wd [2];
    logic          pv_we [2];
    logic [PW-1:0] pv_wa [2];
    logic [PW-1:0] pv_wd [2];
    logic          vl_we;
    logic [PW-1:0] vl_wa;
    logic [VALUE_BITS-1:0] vl_wd;
    logic          sl;
    logic          h_ok, t_ok, c_ok;

    // node memories
    dllc_ram #(.DEPTH(NODES), .WIDTH(PW)) u_next (
        .i_clk(i_clk), .i_we(nx_we[sl] && (r_state == S_X || r_state == S_W)),
        .i_waddr(nx_wa[sl][AW-1:0]), .i_wdata(nx_wd[sl]),
        .i_re(re), .i_raddr(raddr), .o_rdata(nq)
    );
    dllc_ram #(.DEPTH(NODES), .WIDTH(PW)) u_prev (
        .i_clk(i_clk), .i_we(pv_we[sl] && (r_state == S_X || r_state == S_W)),
        .i_waddr(pv_wa[sl][AW-1:0]), .i_wdata(pv_wd[sl]),
        .i_re(re), .i_raddr(raddr), .o_rdata(pq)
    );
    dllc_ram #(.DEPTH(NODES), .WIDTH(VALUE_BITS)) u_value (
        .i_clk(i_clk), .i_we(vl_we && r_state == S_X),
        .i_waddr(vl_wa[AW-1:0]), .i_wdata(vl_wd),
        .i_re(re), .i_raddr(raddr), .o_rdata(vq)
    );

    dllc_alloc #(.NODES(NODES)) u_alloc (
        .i_in_use(r_use), .o_idx(alloc_idx), .o_full(full)
    );

    assign nn   = PW'(alloc_idx);
    assign h_ok = r_head < NONE;
    assign t_ok = r_tail < NONE;
    assign c_ok = r_cur < NONE;
    assign sl   = (r_state == S_W);

    // read address: first the node the op works on, then the deleted neighbor
    always_comb begin
        priority if (r_cmd.op == OP_GET_FIRST || r_cmd.op == OP_DEL_FIRST) begin
            rptr = r_head;
        end else if (r_cmd.op == OP_GET_LAST || r_cmd.op == OP_DEL_LAST) begin
            rptr = r_tail;
        end else begin
            rptr = r_cur;
        end
        re    = (r_state == S_R1) || (r_state == S_R2);
        raddr = (r_state == S_R2) ? ((r_cmd.op == OP_DEL_AFTER) ? nq[AW-1:0] : pq[AW-1:0])
                                  : rptr[AW-1:0];
    end

    // operation decode: link writes in two slots, pointer and pool updates
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            nx_we[s] = 1'b0; nx_wa[s] = '0; nx_wd[s] = NONE;
            pv_we[s] = 1'b0; pv_wa[s] = '0; pv_wd[s] = NONE;
        end
        vl_we = 1'b0;
        vl_wa = nn;
        vl_wd = VALUE_BITS'(r_cmd.value);
        n_head = r_head;
        n_tail = r_tail;
        n_cur  = r_cur;
        n_use  = r_use;
        n_rsp.read_value = '0;
        n_rsp.error      = 1'b0;
        unique case (r_cmd.op)
            OP_CLEAR: begin
                n_use  = '0;
                n_head = NONE;
                n_tail = NONE;
                n_cur  = NONE;
            end
            OP_INS_FIRST: begin
                if (full) begin
                    n_rsp.error = 1'b1;
                end else begin
                    nx_we[0] = 1'b1; nx_wa[0] = nn; nx_wd[0] = r_head;
                    pv_we[0] = 1'b1; pv_wa[0] = nn; pv_wd[0] = NONE;
                    pv_we[1] = h_ok; pv_wa[1] = r_head; pv_wd[1] = nn;
                    vl_we = 1'b1;
                    n_head = nn;
                    if (!h_ok) n_tail = nn;
                    n_use[alloc_idx] = 1'b1;
                end
            end
            OP_INS_LAST: begin
                if (full) begin
                    n_rsp.error = 1'b1;
                end else begin
                    nx_we[0] = 1'b1; nx_wa[0] = nn; nx_wd[0] = NONE;
                    nx_we[1] = t_ok; nx_wa[1] = r_tail; nx_wd[1] = nn;
                    pv_we[0] = 1'b1; pv_wa[0] = nn; pv_wd[0] = r_tail;
                    vl_we = 1'b1;
                    n_tail = nn;
                    if (!t_ok) n_head = nn;
                    n_use[alloc_idx] = 1'b1;
                end
            end
            OP_FIRST: n_cur = r_head;
            OP_LAST:  n_cur = r_tail;
            OP_GET_FIRST, OP_GET_LAST, OP_GET: begin
                if ((r_cmd.op == OP_GET_FIRST && h_ok) || (r_cmd.op == OP_GET_LAST && t_ok)
                    || (r_cmd.op == OP_GET && c_ok)) begin
                    n_rsp.read_value = 32'($signed(vq));
                end else begin
                    n_rsp.error = 1'b1;
                end
            end
            OP_DEL_FIRST: begin
                if (h_ok) begin
                    if (r_cur == r_head) n_cur = NONE;
                    if (nq < NONE) begin
                        n_head = nq;
                        pv_we[0] = 1'b1; pv_wa[0] = nq; pv_wd[0] = NONE;
                    end else begin
                        n_head = NONE;
                        n_tail = NONE;
                    end
                    n_use[r_head[AW-1:0]] = 1'b0;
                end
            end
            OP_DEL_LAST: begin
                if (t_ok) begin
                    if (r_cur == r_tail) n_cur = NONE;
                    if (pq < NONE) begin
                        n_tail = pq;
                        nx_we[0] = 1'b1; nx_wa[0] = pq; nx_wd[0] = NONE;
                    end else begin
                        n_head = NONE;
                        n_tail = NONE;
                    end
                    n_use[r_tail[AW-1:0]] = 1'b0;
                end
            end
            OP_DEL_AFTER: begin
                // r_lnk is the deleted node, nq its successor
                if (c_ok && r_lnk < NONE) begin
                    nx_we[0] = 1'b1; nx_wa[0] = r_cur; nx_wd[0] = nq;
                    if (nq < NONE) begin
                        pv_we[0] = 1'b1; pv_wa[0] = nq; pv_wd[0] = r_cur;
                    end else begin
                        n_tail = r_cur;
                    end
                    n_use[r_lnk[AW-1:0]] = 1'b0;
                end
            end
            OP_DEL_BEFORE: begin
                if (c_ok && r_lnk < NONE) begin
                    pv_we[0] = 1'b1; pv_wa[0] = r_cur; pv_wd[0] = pq;
                    if (pq < NONE) begin
                        nx_we[0] = 1'b1; nx_wa[0] = pq; nx_wd[0] = r_cur;
                    end else begin
                        n_head = r_cur;
                    end
                    n_use[r_lnk[AW-1:0]] = 1'b0;
                end
            end
            OP_INS_AFTER: begin
                if (c_ok && full) begin
                    n_rsp.error = 1'b1;
                end else if (c_ok) begin
                    nx_we[0] = 1'b1; nx_wa[0] = nn; nx_wd[0] = nq;
                    nx_we[1] = 1'b1; nx_wa[1] = r_cur; nx_wd[1] = nn;
                    pv_we[0] = 1'b1; pv_wa[0] = nn; pv_wd[0] = r_cur;
                    pv_we[1] = (nq < NONE); pv_wa[1] = nq; pv_wd[1] = nn;
                    vl_we = 1'b1;
                    if (r_cur == r_tail) n_tail = nn;
                    n_use[alloc_idx] = 1'b1;
                end
            end
            OP_INS_BEFORE: begin
                if (c_ok && full) begin
                    n_rsp.error = 1'b1;
                end else if (c_ok) begin
                    pv_we[0] = 1'b1; pv_wa[0] = nn; pv_wd[0] = pq;
                    pv_we[1] = 1'b1; pv_wa[1] = r_cur; pv_wd[1] = nn;
                    nx_we[0] = 1'b1; nx_wa[0] = nn; nx_wd[0] = r_cur;
                    nx_we[1] = (pq < NONE); nx_wa[1] = pq; nx_wd[1] = nn;
                    vl_we = 1'b1;
                    if (r_cur == r_head) n_head = nn;
                    n_use[alloc_idx] = 1'b1;
                end
            end
            OP_SET: begin
                vl_we = c_ok;
                vl_wa = r_cur;
            end
            OP_NEXT: if (c_ok) n_cur = nq;
            OP_PREV: if (c_ok) n_cur = pq;
            default: ;
        endcase
        n_rsp.cursor_valid = n_cur < NONE;
    end

    // sequencer
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = start ? S_R1 : S_IDLE;
            S_R1:    n_state = (r_cmd.op == OP_DEL_AFTER || r_cmd.op == OP_DEL_BEFORE)
                               ? S_R2 : S_X;
            S_R2:    n_state = S_X;
            S_X:     n_state = S_W;
            S_W:     n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NONE;
            r_tail  <= NONE;
            r_cur   <= NONE;
            r_use   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_W);
            if (r_state == S_W) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_cur  <= n_cur;
                r_use  <= n_use;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) r_cmd <= i_cmd;
        if (r_state == S_R2) r_lnk <= (r_cmd.op == OP_DEL_AFTER) ? nq : pq;
        if (r_state == S_W) r_rsp <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted command not worked");
    a_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE) == (r_tail == NONE)) else $error("head and tail disagree");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.error) |-> (o_rsp.read_value == '0)) else $error("error with data");

endmodule

FILE: design/dllc_ram.sv
// synchronous memory, one write port and one registered read port
// uses dllc_pkg only for house consistency of defaults
`timescale 1ns / 1ps
module dllc_ram #(
    parameter int DEPTH = dllc_pkg::DefNodes,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import dllc_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/dllc_alloc.sv
// lowest free node finder over the in-use vector
// uses dllc_pkg defaults
`timescale 1ns / 1ps
module dllc_alloc #(
    parameter int NODES = dllc_pkg::DefNodes
) (
    input  logic [NODES-1:0]         i_in_use,
    output logic [$clog2(NODES)-1:0] o_idx,
    output logic                     o_full
);
    import dllc_pkg::*;

    localparam int AW = $clog2(NODES);

    // priority pick, highest index scanned first so the lowest wins
    always_comb begin
        o_idx  = '0;
        o_full = 1'b1;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (!i_in_use[i]) begin
                o_idx  = AW'(i);
                o_full = 1'b0;
            end
        end
    end

endmodule

FILE: verif/tb_doubly_linked_list_with_cursor.sv
// testbench for the linked list node pool: random and directed command streams
// checked against an in-bench list predictor; depends on dllc_pkg and the dut
`timescale 1ns / 1ps
module tb_doubly_linked_list_with_cursor;
    import dllc_pkg::*;

    localparam int NODES = 16;
    localparam int SLOTS = 32;
    localparam logic [4:0] NIL = 5'd16;
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_cmd i_cmd = '0;
    logic o_done;
    t_rsp o_rsp;

    doubly_linked_list_with_cursor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_done(o_done), .o_rsp(o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the list, sized for the full 5-bit link code
    logic [31:0] lst_val [SLOTS];
    logic [4:0]  lst_next [SLOTS];
    logic [4:0]  lst_prev [SLOTS];
    logic [SLOTS-1:0] lst_used;
    logic [4:0] lst_head, lst_tail, lst_cur;

    t_cmd cmd_q [$];
    t_rsp rsp_q [$];
    int   err_cnt = 0;
    int   idle_cnt = 0;
    bit   stim_done = 0;
    bit   calm = 0;

    function automatic bit is_node(logic [4:0] p);
        return p < NIL;
    endfunction

    function automatic logic [4:0] grab_node(logic [31:0] v);
        for (int i = 0; i < NODES; i++) begin
            if (!lst_used[i]) begin
                lst_used[i] = 1'b1;
                lst_val[i] = v;
                lst_next[i] = NIL;
                lst_prev[i] = NIL;
                return 5'(i);
            end
        end
        return NIL;
    endfunction

    // apply one command to the predicted list and return the expected result
    function automatic t_rsp apply_cmd(t_cmd c);
        t_rsp r;
        logic [4:0] n, d, x;
        r = '0;
        case (c.op)
            OP_CLEAR: begin
                lst_used = '0;
                lst_head = NIL; lst_tail = NIL; lst_cur = NIL;
            end
            OP_INS_FIRST: begin
                n = grab_node(c.value);
                if (!is_node(n)) r.error = 1'b1;
                else begin
                    lst_next[n] = lst_head;
                    if (is_node(lst_head)) lst_prev[lst_head] = n;
                    else lst_tail = n;
                    lst_head = n;
                end
            end
            OP_INS_LAST: begin
                n = grab_node(c.value);
                if (!is_node(n)) r.error = 1'b1;
                else begin
                    lst_prev[n] = lst_tail;
                    if (is_node(lst_tail)) lst_next[lst_tail] = n;
                    else lst_head = n;
                    lst_tail = n;
                end
            end
            OP_FIRST: lst_cur = lst_head;
            OP_LAST: lst_cur = lst_tail;
            OP_GET_FIRST: begin
                if (is_node(lst_head)) r.read_value = lst_val[lst_head];
                else r.error = 1'b1;
            end
            OP_GET_LAST: begin
                if (is_node(lst_tail)) r.read_value = lst_val[lst_tail];
                else r.error = 1'b1;
            end
            OP_DEL_FIRST: begin
                if (is_node(lst_head)) begin
                    if (lst_cur == lst_head) lst_cur = NIL;
                    d = lst_head;
                    x = lst_next[d];
                    if (is_node(x)) begin
                        lst_head = x; lst_prev[x] = NIL;
                    end else begin
                        lst_head = NIL; lst_tail = NIL;
                    end
                    lst_used[d] = 1'b0;
                end
            end
            OP_DEL_LAST: begin
                if (is_node(lst_tail)) begin
                    if (lst_cur == lst_tail) lst_cur = NIL;
                    d = lst_tail;
                    x = lst_prev[d];
                    if (is_node(x)) begin
                        lst_tail = x; lst_next[x] = NIL;
                    end else begin
                        lst_head = NIL; lst_tail = NIL;
                    end
                    lst_used[d] = 1'b0;
                end
            end
            OP_DEL_AFTER: begin
                if (is_node(lst_cur) && is_node(lst_next[lst_cur])) begin
                    d = lst_next[lst_cur];
                    x = lst_next[d];
                    lst_next[lst_cur] = x;
                    if (is_node(x)) lst_prev[x] = lst_cur;
                    else lst_tail = lst_cur;
                    lst_used[d] = 1'b0;
                end
            end
            OP_DEL_BEFORE: begin
                if (is_node(lst_cur) && is_node(lst_prev[lst_cur])) begin
                    d = lst_prev[lst_cur];
                    x = lst_prev[d];
                    lst_prev[lst_cur] = x;
                    if (is_node(x)) lst_next[x] = lst_cur;
                    else lst_head = lst_cur;
                    lst_used[d] = 1'b0;
                end
            end
            OP_INS_AFTER: begin
                if (is_node(lst_cur)) begin
                    n = grab_node(c.value);
                    if (!is_node(n)) r.error = 1'b1;
                    else begin
                        x = lst_next[lst_cur];
                        lst_prev[n] = lst_cur;
                        lst_next[n] = x;
                        if (is_node(x)) lst_prev[x] = n;
                        lst_next[lst_cur] = n;
                        if (lst_cur == lst_tail) lst_tail = n;
                    end
                end
            end
            OP_INS_BEFORE: begin
                if (is_node(lst_cur)) begin
                    n = grab_node(c.value);
                    if (!is_node(n)) r.error = 1'b1;
                    else begin
                        x = lst_prev[lst_cur];
                        lst_next[n] = lst_cur;
                        lst_prev[n] = x;
                        if (is_node(x)) lst_next[x] = n;
                        lst_prev[lst_cur] = n;
                        if (lst_cur == lst_head) lst_head = n;
                    end
                end
            end
            OP_GET: begin
                if (is_node(lst_cur)) r.read_value = lst_val[lst_cur];
                else r.error = 1'b1;
            end
            OP_SET: if (is_node(lst_cur)) lst_val[lst_cur] = c.value;
            OP_NEXT: if (is_node(lst_cur)) lst_cur = lst_next[lst_cur];
            OP_PREV: if (is_node(lst_cur)) lst_cur = lst_prev[lst_cur];
            default: ;
        endcase
        r.cursor_valid = is_node(lst_cur);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    function automatic t_cmd mk(logic [4:0] op, logic [31:0] v);
        t_cmd c;
        c.op = op;
        c.value = v;
        return c;
    endfunction

    // weighted random op: mostly list work, some unknown codes
    function automatic t_cmd rand_cmd();
        int k;
        logic [4:0] op;
        k = $urandom_range(0, 99);
        if (k < 1) op = OP_CLEAR;
        else if (k < 4) op = 5'($urandom_range(18, 31));
        else if (k < 22) op = ($urandom_range(0, 1)) ? OP_INS_FIRST : OP_INS_LAST;
        else if (k < 32) op = ($urandom_range(0, 1)) ? OP_INS_AFTER : OP_INS_BEFORE;
        else if (k < 44) op = ($urandom_range(0, 1)) ? OP_NEXT : OP_PREV;
        else op = 5'($urandom_range(3, 17));
        return mk(op, $urandom);
    endfunction

    // driver: present commands at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !busy) && start) begin
            // previous command not yet taken: hold it
        end else if (i_rst_n && cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
            i_cmd <= cmd_q.pop_front();
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: predict on accept, check on strobe
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
            if (start && !busy) begin
                rsp_q.push_back(apply_cmd(i_cmd));
            end
            if (o_done) begin
                if (rsp_q.size() == 0) begin
                    report_mismatch("result with no command pending", 32'(o_done), 32'd0);
                end else begin
                    t_rsp w;
                    w = rsp_q.pop_front();
                    if (o_rsp.read_value !== w.read_value)
                        report_mismatch("read_value", o_rsp.read_value, w.read_value);
                    if (o_rsp.error !== w.error)
                        report_mismatch("error", 32'(o_rsp.error), 32'(w.error));
                    if (o_rsp.cursor_valid !== w.cursor_valid)
                        report_mismatch("cursor_valid", 32'(o_rsp.cursor_valid),
                                        32'(w.cursor_valid));
                end
            end
            if (idle_cnt >= STALL_LIMIT) begin
                $display("FAIL doubly_linked_list_with_cursor");
                $finish;
            end
        end
    end

    initial begin
        lst_used = '0;
        lst_head = NIL; lst_tail = NIL; lst_cur = NIL;
        for (int i = 0; i < SLOTS; i++) begin
            lst_val[i] = '0; lst_next[i] = NIL; lst_prev[i] = NIL;
        end
        // directed: empty-list reads, cursor ops without cursor, extremes
        cmd_q.push_back(mk(OP_GET_FIRST, 0));
        cmd_q.push_back(mk(OP_GET, 0));
        cmd_q.push_back(mk(OP_INS_AFTER, 5));
        cmd_q.push_back(mk(OP_DEL_FIRST, 0));
        cmd_q.push_back(mk(OP_INS_LAST, 32'h8000_0000));
        cmd_q.push_back(mk(OP_LAST, 0));
        cmd_q.push_back(mk(OP_INS_AFTER, 32'h7fff_ffff));
        cmd_q.push_back(mk(OP_GET_LAST, 0));
        cmd_q.push_back(mk(OP_INS_BEFORE, 32'hffff_ffff));
        cmd_q.push_back(mk(OP_DEL_AFTER, 0));
        cmd_q.push_back(mk(OP_DEL_BEFORE, 0));
        cmd_q.push_back(mk(OP_SET, 32'h5555_aaaa));
        cmd_q.push_back(mk(OP_GET, 0));
        cmd_q.push_back(mk(OP_PREV, 0));
        cmd_q.push_back(mk(OP_IS_ACTIVE, 0));
        cmd_q.push_back(mk(5'd31, 32'hffff_ffff));
        // fill the pool past full
        for (int i = 0; i < 17; i++) cmd_q.push_back(mk(OP_INS_FIRST, $urandom));
        cmd_q.push_back(mk(OP_FIRST, 0));
        cmd_q.push_back(mk(OP_DEL_LAST, 0));
        cmd_q.push_back(mk(OP_CLEAR, 0));
        // random part
        for (int i = 0; i < 1150; i++) cmd_q.push_back(rand_cmd());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // quiet stretch with no idling in the middle of the run
        wait (cmd_q.size() < 700);
        calm = 1;
        wait (cmd_q.size() < 450);
        calm = 0;
        wait (cmd_q.size() == 0);
        @(posedge i_clk);
        while (start || busy || rsp_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && rsp_q.size() == 0) begin
            $display("PASS doubly_linked_list_with_cursor");
        end else begin
            $display("FAIL doubly_linked_list_with_cursor");
        end
        $finish;
    end
endmodule

FILE: files.f
design/dllc_pkg.sv
design/dllc_ram.sv
design/dllc_alloc.sv
design/doubly_linked_list_with_cursor.sv
verif/tb_doubly_linked_list_with_cursor.sv
